// ----- hdl/fsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and character codes shared by the format specification parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_POUND = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_H     = 8'h68;

  localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_HH   = 3'd1;
  localparam logic [2:0] LEN_H    = 3'd2;
  localparam logic [2:0] LEN_L    = 3'd3;
  localparam logic [2:0] LEN_LL   = 3'd4;
  localparam logic [2:0] LEN_J    = 3'd5;
  localparam logic [2:0] LEN_Z    = 3'd6;

  typedef struct packed {
    logic [7:0]         char_byte;
    logic signed [31:0] star_value;
  } spec_in_t;

  typedef struct packed {
    logic               left_justify;
    logic               alt_form;
    logic               force_sign;
    logic               zero_pad;
    logic               space_sign;
    logic [30:0]        field_width;
    logic               prec_given;
    logic signed [31:0] precision_value;
    logic [2:0]         length_code;
    logic [7:0]         conversion;
  } spec_out_t;

endpackage

// ----- hdl/fsp_digit_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_digit_acc
// Saturating decimal accumulate: acc * 10 + digit, clamped to 2^31 - 1.
// ----------------------------------------------------------------------------
module fsp_digit_acc
  import fsp_pkg::*;
(
  input  logic [30:0] acc,
  input  logic [3:0]  digit,
  output logic [30:0] sum
);

  logic [34:0] prod;

  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, digit};
  assign sum  = (prod[34:31] != 4'd0) ? SAT_MAX : prod[30:0];

endmodule

// ----- hdl/fsp_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_parse
// Parser state and per-byte decode. Holds the lookahead phase and the
// accumulated fields; flags a finished record on the conversion byte.
// ----------------------------------------------------------------------------
module fsp_parse
  import fsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  spec_in_t  item,
  output logic      emit,
  output spec_out_t result
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_FLAGS,
    PH_STAR_PEND,
    PH_FIRST_DIG,
    PH_WIDTH_DIGS,
    PH_PREC_START,
    PH_AFTER_DOT,
    PH_PREC_DIGS,
    PH_LEN_START,
    PH_AFTER_L,
    PH_AFTER_H,
    PH_CONV
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  flag_bits, flag_bits_next;
  logic [30:0] width_acc, width_acc_next;
  logic [31:0] held_star, held_star_next;
  logic [31:0] prec_acc, prec_acc_next;
  logic        prec_seen, prec_seen_next;
  logic [2:0]  length_sel, length_sel_next;

  logic [7:0]  c;
  logic        is_dig;
  logic [3:0]  dig;
  logic [30:0] w_base, w_sum, p_base, p_sum;
  logic [31:0] star_src, star_neg;
  logic [30:0] star_abs;
  logic        done;
  phase_t      ph;

  assign c      = item.char_byte;
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dig    = c[3:0];

  assign w_base = (phase == PH_FIRST_DIG || phase == PH_WIDTH_DIGS) ? width_acc : 31'd0;
  assign p_base = (phase == PH_PREC_DIGS) ? prec_acc[30:0] : 31'd0;

  fsp_digit_acc u_width_acc (.acc(w_base), .digit(dig), .sum(w_sum));
  fsp_digit_acc u_prec_acc  (.acc(p_base), .digit(dig), .sum(p_sum));

  assign star_src = (phase == PH_STAR_PEND) ? held_star : item.star_value;
  assign star_neg = 32'd0 - star_src;
  assign star_abs = (star_src == 32'h8000_0000) ? SAT_MAX :
                    (star_src[31] ? star_neg[30:0] : star_src[30:0]);

  always_comb begin
    ph              = phase;
    done            = 1'b0;
    emit            = 1'b0;
    flag_bits_next  = flag_bits;
    width_acc_next  = width_acc;
    held_star_next  = held_star;
    prec_acc_next   = prec_acc;
    prec_seen_next  = prec_seen;
    length_sel_next = length_sel;
    result          = '0;

    case (ph)
      PH_IDLE: begin
        ph   = PH_FLAGS;
        done = 1'b1;
      end
      PH_FLAGS: begin
        done = 1'b1;
        if (c == CH_POUND) begin
          flag_bits_next[1] = 1'b1;
        end else if (c == CH_PLUS) begin
          flag_bits_next[2] = 1'b1;
        end else if (c == CH_MINUS) begin
          flag_bits_next[0] = 1'b1;
        end else if (c == CH_ZERO) begin
          flag_bits_next[3] = 1'b1;
        end else if (c == CH_SPACE) begin
          flag_bits_next[4] = 1'b1;
        end else if (c == CH_STAR) begin
          held_star_next = item.star_value;
          ph             = PH_STAR_PEND;
        end else if (is_dig) begin
          width_acc_next = w_sum;
          ph             = PH_FIRST_DIG;
        end else begin
          done = 1'b0;
          ph   = PH_PREC_START;
        end
      end
      PH_STAR_PEND: begin
        if (is_dig) begin
          width_acc_next = w_sum;
          ph             = PH_WIDTH_DIGS;
          done           = 1'b1;
        end else begin
          if (star_src[31]) flag_bits_next[0] = 1'b1;
          width_acc_next = star_abs;
          ph             = PH_PREC_START;
        end
      end
      PH_FIRST_DIG: begin
        if (c == CH_STAR) begin
          if (star_src[31]) flag_bits_next[0] = 1'b1;
          width_acc_next = star_abs;
          ph             = PH_PREC_START;
          done           = 1'b1;
        end else if (is_dig) begin
          width_acc_next = w_sum;
          ph             = PH_WIDTH_DIGS;
          done           = 1'b1;
        end else begin
          ph = PH_PREC_START;
        end
      end
      PH_WIDTH_DIGS: begin
        if (is_dig) begin
          width_acc_next = w_sum;
          done           = 1'b1;
        end else begin
          ph = PH_PREC_START;
        end
      end
      default: ;
    endcase

    if (!done && ph == PH_PREC_START) begin
      if (c == CH_DOT) begin
        prec_seen_next = 1'b1;
        prec_acc_next  = 32'd0;
        ph             = PH_AFTER_DOT;
        done           = 1'b1;
      end else begin
        ph = PH_LEN_START;
      end
    end else if (!done && ph == PH_AFTER_DOT) begin
      if (c == CH_STAR) begin
        prec_acc_next = item.star_value;
        ph            = PH_LEN_START;
        done          = 1'b1;
      end else if (is_dig) begin
        prec_acc_next = {1'b0, p_sum};
        ph            = PH_PREC_DIGS;
        done          = 1'b1;
      end else begin
        ph = PH_LEN_START;
      end
    end else if (!done && ph == PH_PREC_DIGS) begin
      if (is_dig) begin
        prec_acc_next = {1'b0, p_sum};
        done          = 1'b1;
      end else begin
        ph = PH_LEN_START;
      end
    end

    if (!done && ph == PH_LEN_START) begin
      done = 1'b1;
      if (c == CH_J) begin
        length_sel_next = LEN_J;
        ph              = PH_CONV;
      end else if (c == CH_Z) begin
        length_sel_next = LEN_Z;
        ph              = PH_CONV;
      end else if (c == CH_L) begin
        ph = PH_AFTER_L;
      end else if (c == CH_H) begin
        ph = PH_AFTER_H;
      end else begin
        ph   = PH_CONV;
        done = 1'b0;
      end
    end else if (!done && ph == PH_AFTER_L) begin
      if (c == CH_L) begin
        length_sel_next = LEN_LL;
        done            = 1'b1;
      end else begin
        length_sel_next = LEN_L;
      end
      ph = PH_CONV;
    end else if (!done && ph == PH_AFTER_H) begin
      if (c == CH_H) begin
        length_sel_next = LEN_HH;
        done            = 1'b1;
      end else begin
        length_sel_next = LEN_H;
      end
      ph = PH_CONV;
    end

    phase_next = ph;
    if (!done && ph == PH_CONV) begin
      emit                   = 1'b1;
      result.left_justify    = flag_bits_next[0];
      result.alt_form        = flag_bits_next[1];
      result.force_sign      = flag_bits_next[2];
      result.zero_pad        = flag_bits_next[3];
      result.space_sign      = flag_bits_next[4];
      result.field_width     = width_acc_next;
      result.prec_given      = prec_seen_next;
      result.precision_value = prec_seen_next ? prec_acc_next : 32'sd0;
      result.length_code     = length_sel_next;
      result.conversion      = c;
      phase_next             = PH_IDLE;
      flag_bits_next         = 5'd0;
      width_acc_next         = 31'd0;
      held_star_next         = 32'd0;
      prec_acc_next          = 32'd0;
      prec_seen_next         = 1'b0;
      length_sel_next        = LEN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      flag_bits  <= 5'd0;
      width_acc  <= 31'd0;
      held_star  <= 32'd0;
      prec_acc   <= 32'd0;
      prec_seen  <= 1'b0;
      length_sel <= LEN_NONE;
    end else if (en) begin
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      width_acc  <= width_acc_next;
      held_star  <= held_star_next;
      prec_acc   <= prec_acc_next;
      prec_seen  <= prec_seen_next;
      length_sel <= length_sel_next;
    end
  end

endmodule

// ----- hdl/format_spec_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_spec_parser_core
// printf-style conversion specification parser, one byte per transaction.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+------------------------
//   spec     | spec_valid  | spec_stall  | spec_item  (spec_in_t)
//   rec      | rec_valid   | rec_stall   | rec_item   (spec_out_t)
//
// One byte per cycle while spec_stall is low.
// Bytes pass an input register, then the parser decode updates state and
// loads the record register. Reset clears all parser state and both valids.
// spec_stall rises only while the record register is full and stalled and
// the input register is occupied.
// ----------------------------------------------------------------------------
module format_spec_parser_core
  import fsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      spec_valid,
  output logic      spec_stall,
  input  spec_in_t  spec_item,
  output logic      rec_valid,
  input  logic      rec_stall,
  output spec_out_t rec_item
);

  logic      s1_valid;
  spec_in_t  s1_item;
  logic      advance;
  logic      accept;
  logic      emit;
  spec_out_t result;

  assign advance    = s1_valid && !(rec_valid && rec_stall);
  assign spec_stall = s1_valid && !advance;
  assign accept     = spec_valid && !spec_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) s1_item <= spec_item;
  end

  fsp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (s1_item),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (advance && emit) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
    if (advance && emit) rec_item <= result;
  end

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register lost a held byte");

  a_rec_load: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> rec_valid && (rec_item == $past(result)))
    else $error("record not loaded on conversion byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_stall |-> !advance)
    else $error("parser advanced over a stalled record");
`endif

endmodule

// ----- tb/sv/format_spec_parser_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_spec_parser_core_test
// Self-checking bench for the conversion specification parser. A short table
// of specs runs first. Random well-formed specs and noise bytes follow. Both
// channels idle at random, and the record side holds off once for a long
// stretch. Every record is checked field by field, against a typed record where
// the table gives one and else against a byte-level parser model in the bench.
// ----------------------------------------------------------------------------
module format_spec_parser_core_test;
  import fsp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FLAGS, ST_STAR, ST_DIG1, ST_WIDTH, ST_DOT_CHK,
    ST_PREC1, ST_PREC, ST_LEN, ST_L, ST_H, ST_CONV
  } parse_state_t;

  typedef struct packed {
    spec_in_t  item;
    logic      typed;
    spec_out_t rec;
  } dir_row_t;

  localparam int FL_MINUS = 0;
  localparam int FL_POUND = 1;
  localparam int FL_PLUS  = 2;
  localparam int FL_ZERO  = 3;
  localparam int FL_SPACE = 4;

  localparam int RANDOM_ITEMS = 1500;
  localparam int LONG_HOLD_AT = 40;
  localparam int LONG_HOLD    = 400;

  logic      clk;
  logic      rst;
  logic      spec_valid;
  logic      spec_stall;
  spec_in_t  spec_item;
  logic      rec_valid;
  logic      rec_stall;
  spec_out_t rec_item;

  parse_state_t sp_state;
  logic [4:0]   sp_flags;
  logic [30:0]  sp_width;
  logic [31:0]  sp_held;
  logic [31:0]  sp_prec;
  logic         sp_prec_seen;
  logic [2:0]   sp_len;

  spec_out_t pending_records[$];
  spec_in_t  byte_q[$];
  int        errors;
  int        records_seen;
  int        tx_calm;

  format_spec_parser_core dut (
    .clk        (clk),
    .rst        (rst),
    .spec_valid (spec_valid),
    .spec_stall (spec_stall),
    .spec_item  (spec_item),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec_item   (rec_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------- parser model ----------------

  function automatic bit is_dec_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [31:0] sat_digit(logic [31:0] acc, logic [7:0] c);
    logic [63:0] v;
    v = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
    return (v > {33'd0, SAT_MAX}) ? {1'b0, SAT_MAX} : v[31:0];
  endfunction

  task automatic star_width(logic [31:0] v);
    if (v[31]) begin
      sp_flags[FL_MINUS] = 1'b1;
      v = (v == 32'h8000_0000) ? {1'b0, SAT_MAX} : -v;
    end
    sp_width = v[30:0];
  endtask

  task automatic clear_parse();
    sp_state     = ST_IDLE;
    sp_flags     = '0;
    sp_width     = '0;
    sp_held      = '0;
    sp_prec      = '0;
    sp_prec_seen = 1'b0;
    sp_len       = LEN_NONE;
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic [31:0] sv,
                            output bit emit, output spec_out_t rec);
    bit again;
    logic [31:0] w;
    emit  = 1'b0;
    rec   = '0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (sp_state)
        ST_IDLE: sp_state = ST_FLAGS;
        ST_FLAGS: begin
          if (c == CH_POUND) sp_flags[FL_POUND] = 1'b1;
          else if (c == CH_PLUS) sp_flags[FL_PLUS] = 1'b1;
          else if (c == CH_MINUS) sp_flags[FL_MINUS] = 1'b1;
          else if (c == CH_ZERO) sp_flags[FL_ZERO] = 1'b1;
          else if (c == CH_SPACE) sp_flags[FL_SPACE] = 1'b1;
          else if (c == CH_STAR) begin
            sp_held  = sv;
            sp_state = ST_STAR;
          end else if (is_dec_digit(c)) begin
            w        = sat_digit(32'd0, c);
            sp_width = w[30:0];
            sp_state = ST_DIG1;
          end else begin
            sp_state = ST_DOT_CHK;
            again    = 1'b1;
          end
        end
        ST_STAR: begin
          if (is_dec_digit(c)) begin
            w        = sat_digit(32'd0, c);
            sp_width = w[30:0];
            sp_state = ST_WIDTH;
          end else begin
            star_width(sp_held);
            sp_state = ST_DOT_CHK;
            again    = 1'b1;
          end
        end
        ST_DIG1: begin
          if (c == CH_STAR) begin
            star_width(sv);
            sp_state = ST_DOT_CHK;
          end else if (is_dec_digit(c)) begin
            w        = sat_digit({1'b0, sp_width}, c);
            sp_width = w[30:0];
            sp_state = ST_WIDTH;
          end else begin
            sp_state = ST_DOT_CHK;
            again    = 1'b1;
          end
        end
        ST_WIDTH: begin
          if (is_dec_digit(c)) begin
            w        = sat_digit({1'b0, sp_width}, c);
            sp_width = w[30:0];
          end else begin
            sp_state = ST_DOT_CHK;
            again    = 1'b1;
          end
        end
        ST_DOT_CHK: begin
          if (c == CH_DOT) begin
            sp_prec_seen = 1'b1;
            sp_prec      = '0;
            sp_state     = ST_PREC1;
          end else begin
            sp_state = ST_LEN;
            again    = 1'b1;
          end
        end
        ST_PREC1: begin
          if (c == CH_STAR) begin
            sp_prec  = sv;
            sp_state = ST_LEN;
          end else if (is_dec_digit(c)) begin
            sp_prec  = sat_digit(32'd0, c);
            sp_state = ST_PREC;
          end else begin
            sp_state = ST_LEN;
            again    = 1'b1;
          end
        end
        ST_PREC: begin
          if (is_dec_digit(c)) sp_prec = sat_digit(sp_prec, c);
          else begin
            sp_state = ST_LEN;
            again    = 1'b1;
          end
        end
        ST_LEN: begin
          if (c == CH_J) begin
            sp_len   = LEN_J;
            sp_state = ST_CONV;
          end else if (c == CH_Z) begin
            sp_len   = LEN_Z;
            sp_state = ST_CONV;
          end else if (c == CH_L) sp_state = ST_L;
          else if (c == CH_H) sp_state = ST_H;
          else begin
            sp_state = ST_CONV;
            again    = 1'b1;
          end
        end
        ST_L: begin
          sp_state = ST_CONV;
          if (c == CH_L) sp_len = LEN_LL;
          else begin
            sp_len = LEN_L;
            again  = 1'b1;
          end
        end
        ST_H: begin
          sp_state = ST_CONV;
          if (c == CH_H) sp_len = LEN_HH;
          else begin
            sp_len = LEN_H;
            again  = 1'b1;
          end
        end
        default: begin
          rec.left_justify    = sp_flags[FL_MINUS];
          rec.alt_form        = sp_flags[FL_POUND];
          rec.force_sign      = sp_flags[FL_PLUS];
          rec.zero_pad        = sp_flags[FL_ZERO];
          rec.space_sign      = sp_flags[FL_SPACE];
          rec.field_width     = sp_width;
          rec.prec_given      = sp_prec_seen;
          rec.precision_value = sp_prec_seen ? sp_prec : 32'd0;
          rec.length_code     = sp_len;
          rec.conversion      = c;
          emit = 1'b1;
          clear_parse();
        end
      endcase
    end
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic spec_out_t mk_rec(logic lj, logic af, logic fs, logic zp, logic ss,
                                       logic [30:0] fw, logic pg, logic [31:0] pv,
                                       logic [2:0] lc, logic [7:0] cv);
    spec_out_t r;
    r.left_justify    = lj;
    r.alt_form        = af;
    r.force_sign      = fs;
    r.zero_pad        = zp;
    r.space_sign      = ss;
    r.field_width     = fw;
    r.prec_given      = pg;
    r.precision_value = pv;
    r.length_code     = lc;
    r.conversion      = cv;
    return r;
  endfunction

  function automatic dir_row_t row(logic [7:0] ch, logic [31:0] sv);
    dir_row_t d;
    d.item.char_byte  = ch;
    d.item.star_value = sv;
    d.typed           = 1'b0;
    d.rec             = '0;
    return d;
  endfunction

  function automatic dir_row_t last_row(logic [7:0] ch, logic [31:0] sv, spec_out_t r);
    dir_row_t d;
    d       = row(ch, sv);
    d.typed = 1'b1;
    d.rec   = r;
    return d;
  endfunction

  function automatic logic [31:0] rand_star();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 200) - 100;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] ch, logic [31:0] sv);
    spec_in_t b;
    b.char_byte  = ch;
    b.star_value = sv;
    byte_q.push_back(b);
  endfunction

  function automatic void push_digits(bit nonzero_first);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && nonzero_first) push_byte(8'(CH_ZERO + $urandom_range(1, 9)), $urandom);
      else push_byte(8'(CH_ZERO + $urandom_range(0, 9)), $urandom);
    end
  endfunction

  function automatic void queue_spec();
    string conv_set;
    logic [7:0] flag_chars[5];
    int n;
    conv_set   = "diouxXcspfeEgGaAn%";
    flag_chars = '{CH_POUND, CH_PLUS, CH_MINUS, CH_ZERO, CH_SPACE};
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom);
      return;
    end
    push_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h25, $urandom);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(0, 1);
    repeat (n) push_byte(flag_chars[$urandom_range(0, 4)], $urandom);
    case ($urandom_range(0, 7))
      2, 3: push_digits(1'b1);
      4: push_byte(CH_STAR, rand_star());
      5: begin
        push_byte(CH_STAR, rand_star());
        push_digits(1'b0);
      end
      6: begin
        push_byte(8'(CH_ZERO + $urandom_range(1, 9)), $urandom);
        push_byte(CH_STAR, rand_star());
      end
      default: ;
    endcase
    case ($urandom_range(0, 5))
      1: push_byte(CH_DOT, $urandom);
      2, 3: begin
        push_byte(CH_DOT, $urandom);
        push_digits(1'b0);
      end
      4: begin
        push_byte(CH_DOT, $urandom);
        push_byte(CH_STAR, rand_star());
      end
      default: ;
    endcase
    case ($urandom_range(0, 7))
      1: begin
        push_byte(CH_H, $urandom);
        push_byte(CH_H, $urandom);
      end
      2: push_byte(CH_H, $urandom);
      3: push_byte(CH_L, $urandom);
      4: begin
        push_byte(CH_L, $urandom);
        push_byte(CH_L, $urandom);
      end
      5: push_byte(CH_J, $urandom);
      6: push_byte(CH_Z, $urandom);
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) push_byte(8'($urandom_range(0, 255)), $urandom);
    else push_byte(conv_set[$urandom_range(0, conv_set.len() - 1)], $urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      tx_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(spec_in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      spec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    spec_valid <= 1'b1;
    spec_item  <= b;
    do @(posedge clk); while (spec_stall);
  endtask

  task automatic note_diff(string fld, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, e, a);
      errors++;
    end
  endtask

  task automatic check_record(spec_out_t got);
    spec_out_t e;
    records_seen++;
    if (pending_records.size() == 0) begin
      $display("%0t: record with none expected, actual %h", $time, got);
      errors++;
      return;
    end
    e = pending_records.pop_front();
    note_diff("left_justify", 32'(e.left_justify), 32'(got.left_justify));
    note_diff("alt_form", 32'(e.alt_form), 32'(got.alt_form));
    note_diff("force_sign", 32'(e.force_sign), 32'(got.force_sign));
    note_diff("zero_pad", 32'(e.zero_pad), 32'(got.zero_pad));
    note_diff("space_sign", 32'(e.space_sign), 32'(got.space_sign));
    note_diff("field_width", 32'(e.field_width), 32'(got.field_width));
    note_diff("prec_given", 32'(e.prec_given), 32'(got.prec_given));
    note_diff("precision_value", e.precision_value, got.precision_value);
    note_diff("length_code", 32'(e.length_code), 32'(got.length_code));
    note_diff("conversion", 32'(e.conversion), 32'(got.conversion));
  endtask

  // ---------------- record side ----------------

  initial begin
    int hold;
    int run;
    int r;
    bit long_done;
    hold      = 0;
    run       = 0;
    long_done = 1'b0;
    rec_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rec_valid && !rec_stall) check_record(rec_item);
      if (!long_done && records_seen == LONG_HOLD_AT) begin
        long_done = 1'b1;
        hold      = LONG_HOLD;
        run       = 0;
      end
      if (hold > 0) begin
        hold--;
        rec_stall <= 1'b1;
      end else if (run > 0) begin
        run--;
        rec_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          run = $urandom_range(0, 6);
          rec_stall <= 1'b0;
        end else if (r < 66) begin
          run = $urandom_range(20, 80);
          rec_stall <= 1'b0;
        end else if (r < 94) begin
          hold = $urandom_range(0, 2);
          rec_stall <= 1'b1;
        end else begin
          hold = $urandom_range(8, 40);
          rec_stall <= 1'b1;
        end
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    dir_row_t  rows[$];
    spec_in_t  b;
    spec_out_t rec;
    bit        emit;
    int        sent;
    errors       = 0;
    records_seen = 0;
    tx_calm      = 0;
    sent         = 0;
    rst          = 1'b1;
    spec_valid   = 1'b0;
    spec_item    = '0;
    clear_parse();

    // plain conversion right after reset
    rows.push_back(row(8'h25, 32'd0));
    rows.push_back(last_row("d", 32'd0,
                            mk_rec(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0,
                                   LEN_NONE, "d")));
    // every flag
    rows.push_back(row(8'h25, 32'hFFFF_FFFF));
    rows.push_back(row(CH_POUND, 32'd0));
    rows.push_back(row(CH_PLUS, 32'd0));
    rows.push_back(row(CH_MINUS, 32'd0));
    rows.push_back(row(CH_SPACE, 32'd0));
    rows.push_back(row(CH_ZERO, 32'd0));
    rows.push_back(last_row("x", 32'hFFFF_FFFF,
                            mk_rec(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, '0, 1'b0, '0,
                                   LEN_NONE, "x")));
    // most negative star width, bare dot, hh, NUL conversion
    rows.push_back(row(8'h25, 32'd0));
    rows.push_back(row(CH_STAR, 32'h8000_0000));
    rows.push_back(row(CH_DOT, 32'h7FFF_FFFF));
    rows.push_back(row(CH_H, 32'd0));
    rows.push_back(row(CH_H, 32'd0));
    rows.push_back(last_row(8'h00, 32'd0,
                            mk_rec(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, SAT_MAX, 1'b1, '0,
                                   LEN_HH, 8'h00)));
    // star then digit, star precision at max, j, conversion 0xFF
    rows.push_back(row(8'h25, 32'd0));
    rows.push_back(row(CH_STAR, 32'd5));
    rows.push_back(row(CH_ZERO + 8'd7, 32'd0));
    rows.push_back(row(CH_DOT, 32'd0));
    rows.push_back(row(CH_STAR, 32'h7FFF_FFFF));
    rows.push_back(row(CH_J, 32'd0));
    rows.push_back(row(8'hFF, 32'h8000_0000));
    // digit then star with a negative value, single l
    rows.push_back(row(8'h25, 32'd0));
    rows.push_back(row(CH_ZERO + 8'd3, 32'd0));
    rows.push_back(row(CH_STAR, -32'sd9));
    rows.push_back(row(CH_L, 32'd0));
    rows.push_back(row("d", 32'd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_byte(rows[i].item);
      parse_byte(rows[i].item.char_byte, rows[i].item.star_value, emit, rec);
      if (rows[i].typed) pending_records.push_back(rows[i].rec);
      else if (emit) pending_records.push_back(rec);
    end

    while (sent < RANDOM_ITEMS) begin
      if (byte_q.size() == 0) queue_spec();
      b = byte_q.pop_front();
      send_byte(b);
      parse_byte(b.char_byte, b.star_value, emit, rec);
      if (emit) pending_records.push_back(rec);
      sent++;
    end
    spec_valid <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- format_spec_parser_core.f -----
hdl/fsp_pkg.sv
hdl/fsp_digit_acc.sv
hdl/fsp_parse.sv
hdl/format_spec_parser_core.sv
tb/sv/format_spec_parser_core_test.sv
